>>> hdl/assert_macros.svh
// shared assertion macros for the serial mouse encoder checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SMPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a stalled transfer keeps its value on the next edge
`define SMPE_ASSERT_HOLD(label, vld, stl, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && (stl)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

>>> hdl/smpe_pkg.sv
package smpe_pkg;

	// item opcodes
	localparam logic [2:0] OP_MOTION = 3'd0;
	localparam logic [2:0] OP_BUTTON = 3'd1;
	localparam logic [2:0] OP_SYNC   = 3'd2;
	localparam logic [2:0] OP_LINES  = 3'd3;
	localparam logic [2:0] OP_TAKE   = 3'd4;

	// button codes, also the bit positions in the held button vector
	localparam logic [1:0] BTN_LEFT   = 2'd0;
	localparam logic [1:0] BTN_RIGHT  = 2'd1;
	localparam logic [1:0] BTN_MIDDLE = 2'd2;
	localparam logic [1:0] BTN_NONE   = 2'd3;

	// identification string lengths and their last byte index
	localparam logic [5:0] ID_LAST_FULL  = 6'd43;
	localparam logic [5:0] ID_LAST_BASIC = 6'd47;

	localparam logic [7:0] ID_CODE_MOUSE = 8'h4D;
	localparam logic [7:0] ID_CODE_3BTN  = 8'h33;
	localparam logic [7:0] CLOSE_BYTE    = 8'h09;
	localparam logic [7:0] TEXT_OFFSET   = 8'h20;

	localparam logic [7:0] PNP_FULL [19] = '{
		8'h08, 8'h01, 8'h24, 8'h31, 8'h2D, 8'h35, 8'h10, 8'h10, 8'h10, 8'h11,
		8'h3C, 8'h3C, 8'h2D, 8'h2F, 8'h35, 8'h33, 8'h25, 8'h3C, 8'h3C
	};
	localparam logic [7:0] PNP_BASIC [19] = '{
		8'h08, 8'h01, 8'h24, 8'h30, 8'h2E, 8'h30, 8'h10, 8'h26, 8'h11, 8'h25,
		8'h3C, 8'h3C, 8'h2D, 8'h2F, 8'h35, 8'h33, 8'h25, 8'h3C, 8'h3C
	};
	// description text in ascii, shifted down by the text offset when sent
	localparam logic [7:0] DESC_FULL [20] = '{
		8'h51, 8'h45, 8'h4D, 8'h55, 8'h20, 8'h4D, 8'h69, 8'h63, 8'h72, 8'h6F,
		8'h73, 8'h6F, 8'h66, 8'h74, 8'h20, 8'h4D, 8'h6F, 8'h75, 8'h73, 8'h65
	};
	localparam logic [7:0] DESC_BASIC [25] = '{
		8'h4D, 8'h69, 8'h63, 8'h72, 8'h6F, 8'h73, 8'h6F, 8'h66, 8'h74, 8'h20,
		8'h53, 8'h65, 8'h72, 8'h69, 8'h61, 8'h6C, 8'h20, 8'h45, 8'h61, 8'h73,
		8'h79, 8'h42, 8'h61, 8'h6C, 8'h6C
	};
	localparam logic [7:0] HEX_CHAR [16] = '{
		8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
		8'h18, 8'h19, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26
	};

	// checksum over closing byte, pnp string and shifted description
	function automatic logic [7:0] id_sum(input logic basic);
		logic [7:0] s;
		int i;
		s = CLOSE_BYTE;
		for (i = 0; i < 19; i++) begin
			s = s + (basic ? PNP_BASIC[i] : PNP_FULL[i]);
		end
		if (basic) begin
			for (i = 0; i < 25; i++) begin
				s = s + DESC_BASIC[i] - TEXT_OFFSET;
			end
		end else begin
			for (i = 0; i < 20; i++) begin
				s = s + DESC_FULL[i] - TEXT_OFFSET;
			end
		end
		return s;
	endfunction

	localparam logic [7:0] SUM_FULL  = id_sum(1'b0);
	localparam logic [7:0] SUM_BASIC = id_sum(1'b1);

	// byte of the identification sequence at a given position
	function automatic logic [7:0] id_rom(input logic basic, input logic [5:0] idx);
		logic [7:0] b;
		logic [5:0] off;
		b = 8'h00;
		off = 6'd0;
		if (basic) begin
			if (idx == 6'd0) begin
				b = ID_CODE_MOUSE;
			end else if (idx < 6'd20) begin
				off = idx - 6'd1;
				b = PNP_BASIC[off[4:0]];
			end else if (idx < 6'd45) begin
				off = idx - 6'd20;
				b = DESC_BASIC[off[4:0]] - TEXT_OFFSET;
			end else if (idx == 6'd45) begin
				b = HEX_CHAR[SUM_BASIC[7:4]];
			end else if (idx == 6'd46) begin
				b = HEX_CHAR[SUM_BASIC[3:0]];
			end else begin
				b = CLOSE_BYTE;
			end
		end else begin
			if (idx == 6'd0) begin
				b = ID_CODE_MOUSE;
			end else if (idx == 6'd1) begin
				b = ID_CODE_3BTN;
			end else if (idx < 6'd21) begin
				off = idx - 6'd2;
				b = PNP_FULL[off[4:0]];
			end else if (idx < 6'd41) begin
				off = idx - 6'd21;
				b = DESC_FULL[off[4:0]] - TEXT_OFFSET;
			end else if (idx == 6'd41) begin
				b = HEX_CHAR[SUM_FULL[7:4]];
			end else if (idx == 6'd42) begin
				b = HEX_CHAR[SUM_FULL[3:0]];
			end else begin
				b = CLOSE_BYTE;
			end
		end
		return b;
	endfunction

	typedef struct packed {
		logic [2:0]         op;
		logic               axis_select;
		logic signed [15:0] delta;
		logic [1:0]         button_select;
		logic               pressed;
		logic               rts_level;
		logic               dtr_level;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic motion;
		logic button;
		logic build;
		logic lines;
		logic idx_clr;
		logic push_pkt;
		logic push_id;
		logic pop;
		logic ld_out_empty;
		logic ld_out_mem;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] op;
		logic       powered;
		logic       lines_on;
		logic       pkt_fits;
		logic       pkt_last;
		logic       id_last;
		logic       fifo_empty;
		logic       out_free;
	} dp_stat_t;

endpackage

>>> hdl/serial_mouse_packet_encoder.sv
// Serial mouse encoder for the three-button serial mouse protocol. Motion, button, sync and
// modem-line items update the mouse state and fill a byte queue of FIFO_DEPTH entries;
// each take-byte item returns one result, the next queued byte or byte_valid 0 when the
// queue is empty. Items are handled one at a time and the queue memory has a single write
// port, so the queued bytes are written one after another: motion, button, power-off and
// other items queue nothing, a sync queues a three-byte or a four-byte packet, and a
// power-on edge queues the three-button identity (44 bytes) or the ball identity (48
// bytes). A take byte goes through the registered memory read (not on an empty queue) and
// waits while the output register is held by out_stall. Power-off empties the queue at once.
// The user must write the profile register only while the block is idle; the block does
// not enforce this.
module serial_mouse_packet_encoder import smpe_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	// sequencing
	smpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// mouse state, packet build and queue control
	smpe_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// byte queue storage
	smpe_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> hdl/smpe_ram.sv
module smpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/smpe_ctrl.sv
module smpe_ctrl import smpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_PKT   = 6'b000100,
		ST_IDENT = 6'b001000,
		ST_POP   = 6'b010000,
		ST_READ  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (stat.op)
					OP_MOTION: begin
						cmd.motion = stat.powered;
					end
					OP_BUTTON: begin
						cmd.button = stat.powered;
					end
					OP_SYNC: begin
						if (stat.powered) begin
							cmd.build = 1'b1;
							cmd.idx_clr = 1'b1;
							if (stat.pkt_fits) begin
								state_d = ST_PKT;
							end
						end
					end
					OP_LINES: begin
						cmd.lines = 1'b1;
						cmd.idx_clr = 1'b1;
						if (stat.lines_on && !stat.powered) begin
							state_d = ST_IDENT;
						end
					end
					OP_TAKE: begin
						state_d = ST_POP;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_PKT: begin
				cmd.push_pkt = 1'b1;
				if (stat.pkt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDENT: begin
				cmd.push_id = 1'b1;
				if (stat.id_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (stat.out_free) begin
					if (stat.fifo_empty) begin
						cmd.ld_out_empty = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.pop = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.ld_out_mem = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> hdl/smpe_dp.sv
module smpe_dp import smpe_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	input  in_item_t                      in_data,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  logic                          out_stall,
	output logic                          out_valid,
	output out_item_t                     out_data,
	output logic                          ram_we,
	output logic [$clog2(FIFO_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(FIFO_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                    ram_rdata
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

	in_item_t        item_q;
	logic            profile_q;
	logic [7:0]      accum_x_q;
	logic [7:0]      accum_y_q;
	logic [2:0]      held_q;
	logic            mchg_q;
	logic [1:0]      lines_q;
	logic [7:0]      pkt_q [4];
	logic            pkt4_q;
	logic [5:0]      idx_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] wr_q;
	logic [CNT_W-1:0] count_q;
	logic            out_valid_q;
	out_item_t       out_data_q;

	logic            powered;
	logic            lines_off;
	logic            btn_ok;
	logic            pkt4_now;
	logic [CNT_W-1:0] room;
	logic            push_en;
	logic            out_xfer;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// profile register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_q <= 1'b0;
		end else if (cfg_wr_en) begin
			profile_q <= cfg_wr_data;
		end
	end

	assign powered   = |lines_q;
	assign lines_off = cmd.lines && !(item_q.rts_level || item_q.dtr_level);
	assign btn_ok    = (item_q.button_select != BTN_NONE)
		&& (!profile_q || (item_q.button_select == BTN_LEFT));
	assign pkt4_now  = !profile_q && (held_q[BTN_MIDDLE] || mchg_q);
	assign room      = FULL_CNT - count_q;

	// modem lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= 2'b00;
		end else if (cmd.lines) begin
			lines_q <= {item_q.dtr_level, item_q.rts_level};
		end
	end

	// motion accumulators, wrapping modulo 256
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_x_q <= 8'h00;
			accum_y_q <= 8'h00;
		end else if (lines_off || cmd.build) begin
			accum_x_q <= 8'h00;
			accum_y_q <= 8'h00;
		end else if (cmd.motion) begin
			if (item_q.axis_select) begin
				accum_y_q <= accum_y_q + item_q.delta[7:0];
			end else begin
				accum_x_q <= accum_x_q + item_q.delta[7:0];
			end
		end
	end

	// button states and middle change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 3'b000;
			mchg_q <= 1'b0;
		end else if (lines_off) begin
			held_q <= 3'b000;
			mchg_q <= 1'b0;
		end else if (cmd.button && btn_ok) begin
			held_q[item_q.button_select] <= item_q.pressed;
			if (item_q.button_select == BTN_MIDDLE) begin
				mchg_q <= 1'b1;
			end
		end else if (cmd.build && pkt4_now) begin
			mchg_q <= 1'b0;
		end
	end

	// packet build
	always_ff @(posedge clk) begin
		if (cmd.build) begin
			pkt_q[0] <= {2'b01, held_q[BTN_LEFT], held_q[BTN_RIGHT] & !profile_q,
				accum_y_q[7:6], accum_x_q[7:6]};
			pkt_q[1] <= {2'b00, accum_x_q[5:0]};
			pkt_q[2] <= {2'b00, accum_y_q[5:0]};
			pkt_q[3] <= {2'b00, held_q[BTN_MIDDLE], 5'b00000};
			pkt4_q   <= pkt4_now;
		end
	end

	// byte sequence index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'd0;
		end else if (cmd.idx_clr) begin
			idx_q <= 6'd0;
		end else if (cmd.push_pkt || cmd.push_id) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	// queue write side
	assign push_en   = (cmd.push_pkt || cmd.push_id) && (count_q != FULL_CNT);
	assign ram_we    = push_en;
	assign ram_waddr = wr_q;
	assign ram_wdata = cmd.push_pkt ? pkt_q[idx_q[1:0]] : id_rom(profile_q, idx_q);

	// queue read side
	assign ram_re    = cmd.pop;
	assign ram_raddr = head_q;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else if (lines_off) begin
			head_q  <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else if (push_en) begin
			wr_q    <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	// output register
	assign out_xfer = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out_empty || cmd.ld_out_mem) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out_empty) begin
			out_data_q <= '{data_byte: 8'h00, byte_valid: 1'b0};
		end else if (cmd.ld_out_mem) begin
			out_data_q <= '{data_byte: ram_rdata, byte_valid: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status toward the controller
	always_comb begin
		stat.op         = item_q.op;
		stat.powered    = powered;
		stat.lines_on   = item_q.rts_level || item_q.dtr_level;
		stat.pkt_fits   = room >= (pkt4_now ? CNT_W'(4) : CNT_W'(3));
		stat.pkt_last   = idx_q[1:0] == (pkt4_q ? 2'd3 : 2'd2);
		stat.id_last    = idx_q == (profile_q ? ID_LAST_BASIC : ID_LAST_FULL);
		stat.fifo_empty = (count_q == '0);
		stat.out_free   = !out_valid_q || !out_stall;
	end

endmodule

>>> hdl/smpe_checker.sv
`include "assert_macros.svh"

module smpe_checker import smpe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_wr_en,
	input logic      cfg_wr_data,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// a stalled result holds
	`SMPE_ASSERT_HOLD(a_out_hold, out_valid, out_stall, out_data, "result changed under stall")

	// an empty-queue result carries a zero byte
	`SMPE_ASSERT(a_empty_zero, (out_valid && !out_data.byte_valid) |-> (out_data.data_byte == 8'h00), "empty result with nonzero byte")

	// one item at a time: the transfer after an accepted item is held off
	`SMPE_ASSERT(a_one_item, (in_valid && !in_stall) |=> in_stall, "second item taken while busy")

	// a take byte never yields a result in the very next cycle
	`SMPE_ASSERT(a_take_latency, (in_valid && !in_stall && (in_data.op == OP_TAKE) && !out_valid) |=> !out_valid, "result appeared too early")

	// profile written only with nothing in flight
	`SMPE_ASSERT(a_cfg_quiet, cfg_wr_en |-> (!in_stall && !out_valid && !$isunknown(cfg_wr_data)), "profile written while busy")

endmodule

bind serial_mouse_packet_encoder smpe_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_wr_en   (cfg_wr_en),
	.cfg_wr_data (cfg_wr_data),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.in_data     (in_data),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_data    (out_data)
);
